// ===== rtl/core/shss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shss_pkg: shared types and constants for the hour sample stager
// Command codes, error codes, the slot cell interface struct and sizes.
// ----------------------------------------------------------------------------
package shss_pkg;

  localparam int unsigned SLOTS_DEF   = 32;
  localparam int unsigned MINUTES_DEF = 60;
  localparam int unsigned CELLS_PER_STAGE = 8;
  localparam logic [7:0]  NO_SLOT     = 8'hFF;
  localparam logic [15:0] TEMP_INVALID = 16'h8000;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_SAMPLE  = 2'd1,
    FUNC_MISSING = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_ARG  = 2'd1,
    ERR_FULL     = 2'd2,
    ERR_BAD_TEMP = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_UPDATE = 2'd2,
    ST_OUT    = 2'd3
  } state_t;

  // Search token passed from cell to cell.
  typedef struct packed {
    logic        active;
    logic [63:0] rom;
    logic        hit;
    logic [7:0]  slot;
  } search_t;

endpackage : shss_pkg
`default_nettype wire

// ===== rtl/core/shss_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shss_in_if / shss_out_if: valid/ready channels of the stager
// Input command channel and result channel.
// ----------------------------------------------------------------------------
interface shss_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] sensor_id;
  logic [31:0] node_number;
  logic [7:0]  minute;
  logic signed [15:0] temp_centi;
  logic        corrected_flag;
  logic [31:0] hour_start;
  modport source (output valid, func, sensor_id, node_number, minute, temp_centi,
                  corrected_flag, hour_start, input ready);
  modport sink (input valid, func, sensor_id, node_number, minute, temp_centi,
                corrected_flag, hour_start, output ready);
endinterface

interface shss_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [1:0]  error_code;
  logic [7:0]  slot_index;
  logic [5:0]  slot_count;
  logic        table_overflowed;
  logic [31:0] samples_total;
  logic [31:0] missing_total;
  logic [31:0] bad_argument_total;
  logic [31:0] overflow_total;
  logic [31:0] bad_temp_total;
  modport source (output valid, ok, error_code, slot_index, slot_count,
                  table_overflowed, samples_total, missing_total,
                  bad_argument_total, overflow_total, bad_temp_total,
                  input ready);
  modport sink (input valid, ok, error_code, slot_index, slot_count,
                table_overflowed, samples_total, missing_total,
                bad_argument_total, overflow_total, bad_temp_total,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/shss_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shss_cell: one slot of the sensor ID table
// Holds one ROM ID and compares it against the search token passing by.
// ----------------------------------------------------------------------------
module shss_cell
  import shss_pkg::*;
#(
  parameter logic [7:0] IDX = 8'd0
) (
  input  wire logic    clk,
  input  wire logic    alloc_en,
  input  wire logic    alloc_sel,
  input  wire logic [63:0] alloc_rom,
  input  wire logic    in_use,
  input  wire search_t tok_in,
  output search_t      tok_out
);

  logic [63:0] rom_r;

  always_ff @(posedge clk) begin
    if (alloc_en && alloc_sel) begin
      rom_r <= alloc_rom;
    end
  end

  // First hit wins; later cells pass the token through.
  always_comb begin
    tok_out = tok_in;
    if (tok_in.active && !tok_in.hit && in_use && rom_r == tok_in.rom) begin
      tok_out.hit  = 1'b1;
      tok_out.slot = IDX;
    end
  end

endmodule : shss_cell
`default_nettype wire

// ===== rtl/core/shss_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shss_chain: row of slot cells with a register every few cells
// A search token enters at cell 0 and ripples down; register stages split
// the row into groups of CELLS_PER_STAGE cells.
// ----------------------------------------------------------------------------
module shss_chain
  import shss_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic [5:0] used,
  input  wire logic    alloc_en,
  input  wire logic [7:0] alloc_idx,
  input  wire logic [63:0] alloc_rom,
  input  wire search_t tok_in,
  output search_t      tok_out
);

  search_t link [SLOTS+1];

  assign link[0] = tok_in;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    search_t c_out;
    shss_cell #(.IDX(8'(g))) u_cell (
      .clk      (clk),
      .alloc_en (alloc_en),
      .alloc_sel(alloc_idx == 8'(g)),
      .alloc_rom(alloc_rom),
      .in_use   (7'(g) < {1'b0, used}),
      .tok_in   (link[g]),
      .tok_out  (c_out)
    );
    if ((g % CELLS_PER_STAGE) == CELLS_PER_STAGE - 1 && g != SLOTS - 1) begin : g_reg
      search_t stage_r;
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stage_r.active <= 1'b0;
        end else begin
          stage_r.active <= c_out.active;
        end
        stage_r.rom  <= c_out.rom;
        stage_r.hit  <= c_out.hit;
        stage_r.slot <= c_out.slot;
      end
      assign link[g+1] = stage_r;
    end else begin : g_wire
      assign link[g+1] = c_out;
    end
  end

  assign tok_out = link[SLOTS];

endmodule : shss_chain
`default_nettype wire

// ===== rtl/core/sensor_hour_sample_stager_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_hour_sample_stager_unit: hour sample stager top level
// Command decode, slot search chain, per-slot and per-minute stores.
// ----------------------------------------------------------------------------
// One command at a time. A start-hour command is followed by a clearing pass
// over all MINUTES*SLOTS entries of the temperature store, during which no
// command is taken (also after reset). In a record command the ID search
// ripples down the cell row with a register every eight cells, then the
// update state writes the slot and minute stores. The result sits in an
// output register until taken.
// ----------------------------------------------------------------------------
module sensor_hour_sample_stager_unit
  import shss_pkg::*;
#(
  parameter int unsigned SLOTS   = SLOTS_DEF,
  parameter int unsigned MINUTES = MINUTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  shss_in_if.sink   in_ch,
  shss_out_if.source out_ch
);

  localparam int unsigned DEPTH = SLOTS * MINUTES;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LAT   = (SLOTS - 1) / CELLS_PER_STAGE;
  localparam int unsigned LW    = $clog2(LAT + 2);

  state_t state_r, state_nxt;

  logic        armed_r;
  logic [31:0] hour_base_r;
  logic [5:0]  used_r;
  logic        sticky_r;
  logic [31:0] cnt_smp_r, cnt_mis_r, cnt_bad_r, cnt_ovf_r, cnt_tmp_r;
  logic        clr_r;
  logic [AW-1:0] clr_addr_r;
  logic [LW-1:0] wait_r;

  logic [1:0]  func_r;
  logic [63:0] rom_r;
  logic [31:0] node_r;
  logic [7:0]  minute_r;
  logic [15:0] temp_r;
  logic        corr_r;

  logic [31:0] slot_node_m [SLOTS];
  logic [5:0]  first_m [SLOTS];
  logic [5:0]  last_m [SLOTS];
  logic [15:0] good_m [SLOTS];
  logic [15:0] miss_m [SLOTS];
  logic [15:0] temp_mem [DEPTH];
  logic        pres_mem [DEPTH];
  logic        corr_mem [DEPTH];

  logic        ov_r;
  logic        ok_r;
  logic [1:0]  err_r;
  logic [7:0]  slot_out_r;

  search_t tok_in, tok_out;
  logic    alloc_en;

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = ov_r && out_ch.ready;

  assign in_ch.ready = (state_r == ST_IDLE) && !clr_r && !ov_r;

  // --- sequencing ---------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) begin
                   state_nxt = (func_t'(in_ch.func) == FUNC_SAMPLE ||
                                func_t'(in_ch.func) == FUNC_MISSING) ?
                               ST_SEARCH : ST_OUT;
                 end
      ST_SEARCH: if (wait_r == LW'(LAT)) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Hold the token at the row input so every stage sees it through the update.
  always_comb begin
    tok_in.active = (state_r == ST_SEARCH) || (state_r == ST_UPDATE);
    tok_in.rom    = rom_r;
    tok_in.hit    = 1'b0;
    tok_in.slot   = NO_SLOT;
  end

  wire arg_bad = !armed_r || (minute_r >= 8'(MINUTES));
  wire is_rec  = (state_r == ST_UPDATE);
  wire full    = ({26'd0, used_r} >= 32'(SLOTS));
  wire [7:0] slot_sel = tok_out.hit ? tok_out.slot : {2'b0, used_r};
  wire [SW-1:0] sidx = slot_sel[SW-1:0];
  wire do_rec = is_rec && !arg_bad && (tok_out.hit || !full);
  wire bad_tmp = (func_t'(func_r) == FUNC_SAMPLE) && (temp_r == TEMP_INVALID);
  wire [AW-1:0] maddr = AW'({24'd0, minute_r} * 32'(SLOTS) + {24'd0, slot_sel});

  assign alloc_en = is_rec && !arg_bad && !tok_out.hit && !full;

  shss_chain #(.SLOTS(SLOTS)) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .used     (used_r),
    .alloc_en (alloc_en),
    .alloc_idx({2'b0, used_r}),
    .alloc_rom(rom_r),
    .tok_in   (tok_in),
    .tok_out  (tok_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      armed_r    <= 1'b0;
      hour_base_r <= '0;
      used_r     <= '0;
      sticky_r   <= 1'b0;
      cnt_smp_r  <= '0;
      cnt_mis_r  <= '0;
      cnt_bad_r  <= '0;
      cnt_ovf_r  <= '0;
      cnt_tmp_r  <= '0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      wait_r     <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) ov_r <= 1'b0;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) clr_r <= 1'b0;
      end
      wait_r <= (state_r == ST_SEARCH) ? wait_r + LW'(1) : '0;
      if (in_fire && func_t'(in_ch.func) == FUNC_START) begin
        armed_r     <= 1'b1;
        hour_base_r <= in_ch.hour_start;
        used_r      <= '0;
        sticky_r    <= 1'b0;
        cnt_smp_r   <= '0;
        cnt_mis_r   <= '0;
        cnt_bad_r   <= '0;
        cnt_ovf_r   <= '0;
        cnt_tmp_r   <= '0;
        clr_r       <= 1'b1;
        clr_addr_r  <= '0;
      end
      if (is_rec) begin
        if (arg_bad) begin
          cnt_bad_r <= cnt_bad_r + 32'd1;
        end else if (!tok_out.hit && full) begin
          cnt_ovf_r <= cnt_ovf_r + 32'd1;
          sticky_r  <= 1'b1;
        end else begin
          if (!tok_out.hit) used_r <= used_r + 6'd1;
          if (func_t'(func_r) == FUNC_MISSING || bad_tmp) begin
            cnt_mis_r <= cnt_mis_r + 32'd1;
          end else begin
            cnt_smp_r <= cnt_smp_r + 32'd1;
          end
          if (bad_tmp) cnt_tmp_r <= cnt_tmp_r + 32'd1;
        end
      end
      if (state_r == ST_OUT) ov_r <= 1'b1;
    end
  end

  // Latch the command and form the result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= in_ch.func;
      rom_r    <= in_ch.sensor_id;
      node_r   <= in_ch.node_number;
      minute_r <= in_ch.minute;
      temp_r   <= in_ch.temp_centi;
      corr_r   <= in_ch.corrected_flag;
      ok_r     <= (func_t'(in_ch.func) == FUNC_START);
      err_r    <= (func_t'(in_ch.func) == FUNC_START) ? ERR_NONE : ERR_BAD_ARG;
      slot_out_r <= NO_SLOT;
    end
    if (is_rec) begin
      if (arg_bad) begin
        ok_r <= 1'b0; err_r <= ERR_BAD_ARG; slot_out_r <= NO_SLOT;
      end else if (!tok_out.hit && full) begin
        ok_r <= 1'b0; err_r <= ERR_FULL; slot_out_r <= NO_SLOT;
      end else begin
        ok_r <= !bad_tmp;
        err_r <= bad_tmp ? ERR_BAD_TEMP : ERR_NONE;
        slot_out_r <= slot_sel;
      end
    end
  end

  // Slot attribute and minute stores.
  always_ff @(posedge clk) begin
    if (do_rec) begin
      slot_node_m[sidx] <= node_r;
      last_m[sidx]      <= minute_r[5:0];
      if (!tok_out.hit || minute_r[5:0] < first_m[sidx]) first_m[sidx] <= minute_r[5:0];
      if (func_t'(func_r) == FUNC_MISSING || bad_tmp) begin
        miss_m[sidx] <= tok_out.hit ? miss_m[sidx] + 16'd1 : 16'd1;
        good_m[sidx] <= tok_out.hit ? good_m[sidx] : 16'd0;
      end else begin
        good_m[sidx] <= tok_out.hit ? good_m[sidx] + 16'd1 : 16'd1;
        miss_m[sidx] <= tok_out.hit ? miss_m[sidx] : 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      temp_mem[clr_addr_r] <= TEMP_INVALID;
      pres_mem[clr_addr_r] <= 1'b0;
      corr_mem[clr_addr_r] <= 1'b0;
    end else if (do_rec) begin
      if (func_t'(func_r) == FUNC_MISSING || bad_tmp) begin
        temp_mem[maddr] <= TEMP_INVALID;
        pres_mem[maddr] <= 1'b0;
        corr_mem[maddr] <= 1'b0;
      end else begin
        temp_mem[maddr] <= temp_r;
        pres_mem[maddr] <= 1'b1;
        corr_mem[maddr] <= corr_r;
      end
    end
  end

  assign out_ch.valid              = ov_r;
  assign out_ch.ok                 = ok_r;
  assign out_ch.error_code         = err_r;
  assign out_ch.slot_index         = slot_out_r;
  assign out_ch.slot_count         = used_r;
  assign out_ch.table_overflowed   = sticky_r;
  assign out_ch.samples_total      = cnt_smp_r;
  assign out_ch.missing_total      = cnt_mis_r;
  assign out_ch.bad_argument_total = cnt_bad_r;
  assign out_ch.overflow_total     = cnt_ovf_r;
  assign out_ch.bad_temp_total     = cnt_tmp_r;

  // --- checks -------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ch.ready) else $error("command taken during clearing pass");
  a_slots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    {26'd0, used_r} <= 32'(SLOTS)) else $error("slot count above table size");
  a_slot_grows_one: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r) && used_r != '0) |-> used_r == $past(used_r) + 6'd1)
    else $error("slot count jumped");

endmodule : sensor_hour_sample_stager_unit
`default_nettype wire

// ===== tb/shss_tb_if.sv =====
// ----------------------------------------------------------------------------
// Testbench channel note
// The block's own channel interfaces (shss_in_if, shss_out_if) are used as
// they are; this file holds the shared timing constants of the bench.
// ----------------------------------------------------------------------------
package shss_tb_pkg;
  localparam int unsigned CLK_HALF   = 5;
  localparam int unsigned IDLE_LIMIT = 20000;
endpackage : shss_tb_pkg

// ===== tb/shss_checker.sv =====
// ----------------------------------------------------------------------------
// Hour stager result checker
// Watches both channels, tracks the hour, slot table and counters, and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module shss_checker
  import shss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  shss_in_if        in_ch,
  shss_out_if       out_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic        ok;
    logic [1:0]  error_code;
    logic [7:0]  slot_index;
    logic [5:0]  slot_count;
    logic        table_overflowed;
    logic [31:0] samples_total;
    logic [31:0] missing_total;
    logic [31:0] bad_argument_total;
    logic [31:0] overflow_total;
    logic [31:0] bad_temp_total;
  } status_t;

  status_t     status_q[$];
  logic        armed;
  logic [5:0]  used;
  logic [63:0] rom_tab[SLOTS_DEF];
  logic        sticky;
  logic [31:0] n_good, n_miss, n_badarg, n_ovf, n_badtemp;

  initial fail_count = 0;
  assign pending = status_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
    fail_count++;
  endtask

  task automatic reset_hour();
    armed = 0; used = 0; sticky = 0;
    n_good = 0; n_miss = 0; n_badarg = 0; n_ovf = 0; n_badtemp = 0;
  endtask

  function automatic status_t snap(logic ok, err_t e, logic [7:0] s);
    status_t r;
    r = '{ok, e, s, used, sticky, n_good, n_miss, n_badarg, n_ovf, n_badtemp};
    return r;
  endfunction

  task automatic predict_command();
    func_t       f;
    logic [7:0]  s;
    f = func_t'(in_ch.func);
    s = NO_SLOT;
    if (f == FUNC_START) begin
      reset_hour();
      armed = 1;
      status_q.push_back(snap(1, ERR_NONE, NO_SLOT));
      return;
    end
    if (f == FUNC_NONE) begin
      status_q.push_back(snap(0, ERR_BAD_ARG, NO_SLOT));
      return;
    end
    if (!armed || in_ch.minute >= MINUTES_DEF) begin
      n_badarg++;
      status_q.push_back(snap(0, ERR_BAD_ARG, NO_SLOT));
      return;
    end
    for (int i = 0; i < used; i++)
      if (s == NO_SLOT && rom_tab[i] == in_ch.sensor_id) s = 8'(i);
    if (s == NO_SLOT) begin
      if (used >= SLOTS_DEF) begin
        n_ovf++;
        sticky = 1;
        status_q.push_back(snap(0, ERR_FULL, NO_SLOT));
        return;
      end
      s = {2'b0, used};
      rom_tab[used] = in_ch.sensor_id;
      used++;
    end
    if (f == FUNC_MISSING) begin
      n_miss++;
      status_q.push_back(snap(1, ERR_NONE, s));
    end else if (in_ch.temp_centi == TEMP_INVALID) begin
      n_badtemp++;
      n_miss++;
      status_q.push_back(snap(0, ERR_BAD_TEMP, s));
    end else begin
      n_good++;
      status_q.push_back(snap(1, ERR_NONE, s));
    end
  endtask

  task automatic check_result();
    status_t got, want;
    got = '{out_ch.ok, out_ch.error_code, out_ch.slot_index, out_ch.slot_count,
            out_ch.table_overflowed, out_ch.samples_total, out_ch.missing_total,
            out_ch.bad_argument_total, out_ch.overflow_total, out_ch.bad_temp_total};
    if (status_q.size() == 0) begin
      report("unexpected result", 0, 0);
      return;
    end
    want = status_q.pop_front();
    if (got.ok != want.ok) report("ok", got.ok, want.ok);
    if (got.error_code != want.error_code) report("error_code", got.error_code, want.error_code);
    if (got.slot_index != want.slot_index) report("slot_index", got.slot_index, want.slot_index);
    if (got.slot_count != want.slot_count) report("slot_count", got.slot_count, want.slot_count);
    if (got.table_overflowed != want.table_overflowed)
      report("table_overflowed", got.table_overflowed, want.table_overflowed);
    if (got.samples_total != want.samples_total)
      report("samples_total", got.samples_total, want.samples_total);
    if (got.missing_total != want.missing_total)
      report("missing_total", got.missing_total, want.missing_total);
    if (got.bad_argument_total != want.bad_argument_total)
      report("bad_argument_total", got.bad_argument_total, want.bad_argument_total);
    if (got.overflow_total != want.overflow_total)
      report("overflow_total", got.overflow_total, want.overflow_total);
    if (got.bad_temp_total != want.bad_temp_total)
      report("bad_temp_total", got.bad_temp_total, want.bad_temp_total);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_hour();
    end else begin
      // result first: a command and its own result never share an edge
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) predict_command();
    end
  end

endmodule

// ===== tb/tb_sensor_hour_sample_stager_unit.sv =====
// ----------------------------------------------------------------------------
// Hour stager testbench
// Drives directed and random commands with random gaps and result stalls;
// the checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sensor_hour_sample_stager_unit;
  import shss_pkg::*;
  import shss_tb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending, n_sent;
  int   idle_cycles = 0;
  logic [63:0] id_pool[40];

  shss_in_if  in_ch();
  shss_out_if out_ch();

  sensor_hour_sample_stager_unit uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  shss_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                    .fail_count(fail_count), .pending(pending));

  always begin
    #CLK_HALF clk = 1;
    #CLK_HALF clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(func_t f, logic [63:0] id, logic [7:0] m, logic [15:0] t,
                      logic [31:0] node, logic corr, logic [31:0] hs);
    repeat (gap_len()) @(negedge clk);
    in_ch.func = f; in_ch.sensor_id = id; in_ch.minute = m; in_ch.temp_centi = t;
    in_ch.node_number = node; in_ch.corrected_flag = corr; in_ch.hour_start = hs;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 0;
    n_sent++;
  endtask

  task automatic send_rand(func_t f, logic [63:0] id, logic [7:0] m);
    logic [15:0] t;
    t = ($urandom_range(0, 15) == 0) ? TEMP_INVALID : 16'($urandom);
    send(f, id, m, t, $urandom, 1'($urandom_range(0, 1)), $urandom);
  endtask

  // result-side stalls
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 30) begin
        out_ch.ready = 0;
        repeat (gap_len()) @(negedge clk);
      end
      out_ch.ready = 1;
    end
  end

  // watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int r, m;
    func_t f;
    n_sent = 0;
    in_ch.valid = 0; in_ch.func = FUNC_START; in_ch.sensor_id = 0; in_ch.minute = 0;
    in_ch.temp_centi = 0; in_ch.node_number = 0; in_ch.corrected_flag = 0;
    in_ch.hour_start = 0;
    foreach (id_pool[i]) id_pool[i] = {$urandom, $urandom};
    id_pool[0] = '0; id_pool[1] = '1;
    repeat (5) @(negedge clk);
    rst_n = 1;

    // directed: unarmed, start, extremes, bad temp, bad minute, unknown
    send(FUNC_SAMPLE, id_pool[0], 0, 16'h0000, 0, 0, 0);
    send(FUNC_NONE, '1, 8'hFF, 16'h7FFF, '1, 1, '1);
    send(FUNC_START, 0, 0, 0, 0, 0, '1);
    send(FUNC_SAMPLE, id_pool[0], 0, 16'h7FFF, '1, 1, 0);
    send(FUNC_SAMPLE, id_pool[1], 59, 16'h8001, 0, 0, 0);
    send(FUNC_SAMPLE, id_pool[1], 60, 16'h0001, 0, 0, 0);
    send(FUNC_MISSING, id_pool[0], 8'hFF, 0, 0, 0, 0);
    send(FUNC_SAMPLE, id_pool[0], 30, TEMP_INVALID, 0, 1, 0);
    send(FUNC_MISSING, id_pool[2], 5, 16'hFFFF, 32'h5555_AAAA, 0, 0);
    send(FUNC_NONE, 0, 0, 0, 0, 0, 0);
    send(FUNC_START, 0, 0, 0, 0, 0, 0);
    // fill the table past full
    for (int i = 0; i < 34; i++) send_rand(FUNC_SAMPLE, id_pool[i + 3], 8'(i % 60));

    // random: mostly well-formed hours over a pool of IDs
    while (n_sent < 950) begin
      r = $urandom_range(0, 199);
      if (r == 0) f = FUNC_START;
      else if (r < 4) f = FUNC_NONE;
      else if (r < 60) f = FUNC_MISSING;
      else f = FUNC_SAMPLE;
      m = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 255) : $urandom_range(0, 59);
      if ($urandom_range(0, 3) == 0) send_rand(f, {$urandom, $urandom}, 8'(m));
      else send_rand(f, id_pool[$urandom_range(0, 39)], 8'(m));
    end

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d commands: hour starts, overflow, bad minutes and temperatures",
             n_sent);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
